>>> src/imuavg_pkg.sv
package imuavg_pkg;

  localparam int NUM_SENSORS = 3;
  localparam int NUM_AXES    = 3;

  typedef enum logic [1:0] {
    MODE_ACCEL    = 2'd0,
    MODE_GYRO     = 2'd1,
    MODE_MAG      = 2'd2,
    MODE_GYRO_CAL = 2'd3
  } mode_e;

  // window bank per sensor
  localparam logic [1:0] SENSOR_ACCEL = 2'd0;
  localparam logic [1:0] SENSOR_GYRO  = 2'd1;
  localparam logic [1:0] SENSOR_MAG   = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_MAG_OFS_X = 2'd0;
  localparam logic [1:0] REG_MAG_OFS_Y = 2'd1;
  localparam logic [1:0] REG_MAG_OFS_Z = 2'd2;

  // three 16-bit axis values: [0] x, [1] y, [2] z
  typedef logic [NUM_AXES-1:0][15:0] axis3_t;

endpackage

>>> src/imuavg_cell.sv
module imuavg_cell
  import imuavg_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   shift_i,
  input  axis3_t d_i,
  output axis3_t q_o
);

  axis3_t value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
    end else if (shift_i) begin
      value_q <= d_i;
    end
  end

  assign q_o = value_q;

endmodule

>>> src/imuavg_cdiv.sv
// Floor division of an unsigned value below 2**N by the constant D, done as a
// multiply by a rounded-up reciprocal. The quotient must fit in 16 bits.
module imuavg_cdiv #(
  parameter int N = 19,
  parameter int D = 8
) (
  input  logic [N-1:0] u_i,
  output logic [15:0]  q_o
);

  localparam int L  = (D > 1) ? $clog2(D) : 0;
  localparam int K  = N + L;
  localparam int MW = N + 2;
  localparam int PW = N + MW;
  localparam logic [MW-1:0] RECIP = MW'(((64'd1 << K) + 64'(D) - 64'd1) / 64'(D));

  logic [PW-1:0] prod;

  assign prod = PW'(u_i) * PW'(RECIP);
  assign q_o  = prod[K+15:K];

endmodule

>>> src/imu_axis_averager_with_offsets.sv
// Three-axis IMU averager with per-sensor offsets.
//
// Input channel: mode_i, in_x_i, in_y_i, in_z_i, taken when in_valid_i is high
// and in_stall_o is low. Output channel: out_x_o, out_y_o, out_z_o,
// sensor_kind_o, calibration_done_o, taken when out_valid_o is high and
// out_stall_i is low. Configuration: cfg_we_i writes cfg_data_i into the
// magnetometer offset named by cfg_index_i; indexes past Z are ignored.
//
// Each sensor has a row of WINDOW_DEPTH cells that shift by one on every word
// of that sensor, plus a running sum per axis. A word moves through three
// registered stages (window update, reciprocal multiply, offset subtract)
// on its way to the output. One word is taken every cycle while in_stall_o
// is low; the word that completes a gyro calibration raises a busy flag for a
// single cycle, holding the output stage while the new offset is multiplied out.
// A stalled output keeps its word; the pipeline stages in front keep filling
// and in_stall_o rises only once they are full.
// Reset clears all windows, sums, offsets and the calibration count at once.
module imu_axis_averager_with_offsets
  import imuavg_pkg::*;
#(
  parameter int WINDOW_DEPTH        = 8,
  parameter int CALIBRATION_SAMPLES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] in_x_i,
  input  logic [15:0] in_y_i,
  input  logic [15:0] in_z_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] out_x_o,
  output logic [15:0] out_y_o,
  output logic [15:0] out_z_o,
  output logic [1:0]  sensor_kind_o,
  output logic        calibration_done_o
);

  localparam int LW = $clog2(WINDOW_DEPTH);
  localparam int SW = 16 + LW;
  localparam int CW = $clog2(CALIBRATION_SAMPLES);
  localparam int UW = 16 + CW;
  localparam logic [SW-1:0] WIN_BIAS = SW'(32768 * WINDOW_DEPTH);
  localparam logic [UW-1:0] CAL_BIAS = UW'(32768 * CALIBRATION_SAMPLES);
  localparam logic [CW-1:0] CAL_LAST = CW'(CALIBRATION_SAMPLES - 1);

  // handshake between stages
  logic mv1, mv2, mv3;
  logic v1_q, v2_q, out_valid_q, busy_q;

  assign mv3        = v2_q && (!out_valid_q || !out_stall_i) && !busy_q;
  assign mv2        = v1_q && (!v2_q || mv3);
  assign in_stall_o = v1_q && !mv2;
  assign mv1        = in_valid_i && !in_stall_o;

  // ---------------- stage 1: window cells and running sums ----------------
  mode_e       in_mode;
  logic [1:0]  sel;
  axis3_t      sample;
  axis3_t      oldest;
  logic [NUM_SENSORS-1:0] shift;
  axis3_t      cell_q [NUM_SENSORS][WINDOW_DEPTH];
  logic signed [SW-1:0] sum_q [NUM_SENSORS][NUM_AXES];
  logic signed [SW-1:0] sum_d [NUM_AXES];
  logic [SW-1:0] u1_q [NUM_AXES];
  mode_e       mode1_q;

  assign in_mode = mode_e'(mode_i);

  always_comb begin
    unique case (in_mode)
      MODE_ACCEL: begin
        sel    = SENSOR_ACCEL;
        sample = {in_z_i, in_y_i, in_x_i};
      end
      MODE_MAG: begin
        // swap X and Y, negate Z with 16-bit wrap
        sel    = SENSOR_MAG;
        sample = {16'(-$signed(in_z_i)), in_x_i, in_y_i};
      end
      MODE_GYRO, MODE_GYRO_CAL: begin
        sel    = SENSOR_GYRO;
        sample = {in_z_i, in_y_i, in_x_i};
      end
      default: begin
        sel    = SENSOR_GYRO;
        sample = {in_z_i, in_y_i, in_x_i};
      end
    endcase
  end

  always_comb begin
    for (int s = 0; s < NUM_SENSORS; s++) begin
      shift[s] = mv1 && (sel == 2'(s));
    end
  end

  for (genvar s = 0; s < NUM_SENSORS; s++) begin : g_sensor
    for (genvar j = 0; j < WINDOW_DEPTH; j++) begin : g_tap
      axis3_t tap_d;
      if (j == 0) begin : g_head
        assign tap_d = sample;
      end else begin : g_body
        assign tap_d = cell_q[s][j-1];
      end
      imuavg_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift[s]),
        .d_i     (tap_d),
        .q_o     (cell_q[s][j])
      );
    end
  end

  assign oldest = cell_q[sel][WINDOW_DEPTH-1];

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      sum_d[a] = sum_q[sel][a] + SW'($signed(sample[a])) - SW'($signed(oldest[a]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SENSORS; s++) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          sum_q[s][a] <= '0;
        end
      end
    end else if (mv1) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        sum_q[sel][a] <= sum_d[a];
      end
    end
  end

  // bias the sum so the floor division works on an unsigned value
  always_ff @(posedge clk_i) begin
    if (mv1) begin
      mode1_q <= in_mode;
      for (int a = 0; a < NUM_AXES; a++) begin
        u1_q[a] <= sum_d[a] + WIN_BIAS;
      end
    end
  end

  // ---------------- stage 2: divide by the window depth ----------------
  logic [15:0] win_q  [NUM_AXES];
  axis3_t      avg2_q;
  mode_e       mode2_q;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_win_div
    imuavg_cdiv #(
      .N (SW),
      .D (WINDOW_DEPTH)
    ) u_div (
      .u_i (u1_q[a]),
      .q_o (win_q[a])
    );
  end

  always_ff @(posedge clk_i) begin
    if (mv2) begin
      mode2_q <= mode1_q;
      for (int a = 0; a < NUM_AXES; a++) begin
        // remove the bias: subtracting 32768 flips the top bit
        avg2_q[a] <= {~win_q[a][15], win_q[a][14:0]};
      end
    end
  end

  // ---------------- stage 3: offsets and calibration ----------------
  axis3_t mag_ofs_q;
  axis3_t gyro_ofs_q;
  axis3_t off;
  axis3_t res;
  logic [CW-1:0] cal_cnt_q;
  logic signed [UW-1:0] cal_sum_q [NUM_AXES];
  logic signed [UW-1:0] cal_sum_d [NUM_AXES];
  logic [UW-1:0] div_u_q [NUM_AXES];
  logic [15:0]   cal_q   [NUM_AXES];
  logic          is_cal;
  logic          done;
  axis3_t        out_q;
  logic [1:0]    kind_q;
  logic          done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_ofs_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MAG_OFS_X: mag_ofs_q[0] <= cfg_data_i;
        REG_MAG_OFS_Y: mag_ofs_q[1] <= cfg_data_i;
        REG_MAG_OFS_Z: mag_ofs_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign is_cal = (mode2_q == MODE_GYRO_CAL);
  assign done   = is_cal && (cal_cnt_q == CAL_LAST);

  always_comb begin
    unique case (mode2_q)
      MODE_ACCEL:    off = '0;
      MODE_GYRO:     off = gyro_ofs_q;
      MODE_MAG:      off = mag_ofs_q;
      // first word of a calibration run sees a cleared offset
      MODE_GYRO_CAL: off = (cal_cnt_q == '0) ? '0 : gyro_ofs_q;
      default:       off = '0;
    endcase
    for (int a = 0; a < NUM_AXES; a++) begin
      res[a]       = avg2_q[a] - off[a];
      cal_sum_d[a] = cal_sum_q[a] + UW'($signed(res[a]));
    end
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_cal_div
    imuavg_cdiv #(
      .N (UW),
      .D (CALIBRATION_SAMPLES)
    ) u_div (
      .u_i (div_u_q[a]),
      .q_o (cal_q[a])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gyro_ofs_q <= '0;
      cal_cnt_q  <= '0;
      busy_q     <= 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
        cal_sum_q[a] <= '0;
      end
    end else if (busy_q) begin
      busy_q <= 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
        gyro_ofs_q[a] <= {~cal_q[a][15], cal_q[a][14:0]};
      end
    end else if (mv3 && is_cal) begin
      if (cal_cnt_q == '0) begin
        gyro_ofs_q <= '0;
      end
      busy_q    <= done;
      cal_cnt_q <= done ? '0 : cal_cnt_q + 1'b1;
      for (int a = 0; a < NUM_AXES; a++) begin
        cal_sum_q[a] <= done ? '0 : cal_sum_d[a];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mv3 && done) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        div_u_q[a] <= cal_sum_d[a] + CAL_BIAS;
      end
    end
  end

  // ---------------- stage valid flags and output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (mv1) begin
        v1_q <= 1'b1;
      end else if (mv2) begin
        v1_q <= 1'b0;
      end
      if (mv2) begin
        v2_q <= 1'b1;
      end else if (mv3) begin
        v2_q <= 1'b0;
      end
      if (mv3) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mv3) begin
      out_q  <= res;
      kind_q <= mode2_q;
      done_q <= done;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_x_o            = out_q[0];
  assign out_y_o            = out_q[1];
  assign out_z_o            = out_q[2];
  assign sensor_kind_o      = kind_q;
  assign calibration_done_o = done_q;

`ifndef NO_ASSERTIONS
  a_done_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && calibration_done_o |-> mode_e'(sensor_kind_o) == MODE_GYRO_CAL)
    else $error("calibration done flagged on a non-calibration word");

  a_busy_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |=> !busy_q)
    else $error("offset update lasted more than one cycle");

  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> out_valid_o && calibration_done_o)
    else $error("offset update without a completing calibration word");

  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> v1_q)
    else $error("accepted word lost at the first stage");
`endif

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;
  import imuavg_pkg::*;

  localparam int AVG_DEPTH   = 8;
  localparam int AVG_SHIFT   = $clog2(AVG_DEPTH);
  localparam int CAL_RUN     = 32;
  localparam int CAL_SHIFT   = $clog2(CAL_RUN);
  localparam int PHASE_WORDS = 167;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic [1:0]  kind;
    logic        done;
  } avg_result_t;

  typedef struct packed {
    mode_e       mode;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
    logic        typed;
    avg_result_t want;
  } stim_row_t;

  localparam int NUM_ROWS = 13;
  localparam stim_row_t DIR_ROWS [NUM_ROWS] = '{
    '{MODE_ACCEL,   16'h7fff, 16'h8000, 16'h0000, 1'b1, '{16'h0fff, 16'hf000, 16'h0000, 2'd0, 1'b0}},
    // mag swaps X/Y and negates Z; -32768 stays -32768
    '{MODE_MAG,     16'h0008, 16'h8000, 16'h8000, 1'b1, '{16'hf000, 16'h0001, 16'hf000, 2'd2, 1'b0}},
    // floor division: -1 averages to -1
    '{MODE_GYRO,    16'h0010, 16'hfff0, 16'hffff, 1'b1, '{16'h0002, 16'hfffe, 16'hffff, 2'd1, 1'b0}},
    '{MODE_ACCEL,   16'hffff, 16'hffff, 16'hffff, 1'b0, '0},
    '{MODE_ACCEL,   16'h8000, 16'h7fff, 16'h7fff, 1'b0, '0},
    '{MODE_MAG,     16'h7fff, 16'h7fff, 16'h7fff, 1'b0, '0},
    '{MODE_GYRO_CAL, 16'h0100, 16'hff00, 16'h0001, 1'b0, '0},
    '{MODE_GYRO,    16'h0005, 16'h0005, 16'h0005, 1'b0, '0},
    '{MODE_GYRO_CAL, 16'h8000, 16'h8000, 16'h8000, 1'b0, '0},
    '{MODE_GYRO_CAL, 16'h7fff, 16'h7fff, 16'h7fff, 1'b0, '0},
    '{MODE_MAG,     16'h0000, 16'h0000, 16'h0000, 1'b0, '0},
    '{MODE_ACCEL,   16'h0000, 16'h0000, 16'h0000, 1'b0, '0},
    '{MODE_GYRO_CAL, 16'hffff, 16'h0000, 16'h8000, 1'b0, '0}
  };

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [1:0]  mode_i      = '0;
  logic [15:0] in_x_i      = '0;
  logic [15:0] in_y_i      = '0;
  logic [15:0] in_z_i      = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] out_x_o;
  logic [15:0] out_y_o;
  logic [15:0] out_z_o;
  logic [1:0]  sensor_kind_o;
  logic        calibration_done_o;

  imu_axis_averager_with_offsets #(
    .WINDOW_DEPTH       (AVG_DEPTH),
    .CALIBRATION_SAMPLES(CAL_RUN)
  ) DUT (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_stall_o,
    .mode_i,
    .in_x_i,
    .in_y_i,
    .in_z_i,
    .out_valid_o,
    .out_stall_i,
    .out_x_o,
    .out_y_o,
    .out_z_o,
    .sensor_kind_o,
    .calibration_done_o
  );

  // predictor state
  logic signed [15:0] hist [NUM_SENSORS][NUM_AXES][AVG_DEPTH];
  int                 slot [NUM_SENSORS];
  logic signed [15:0] gyro_bias [NUM_AXES];
  int                 bias_acc [NUM_AXES];
  int                 bias_count;
  logic signed [15:0] mag_trim [NUM_AXES];

  avg_result_t averages_due [$];
  int          errors       = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic avg_result_t average_word(mode_e m, logic signed [15:0] x,
                                               logic signed [15:0] y,
                                               logic signed [15:0] z);
    avg_result_t        r;
    logic signed [15:0] s [NUM_AXES];
    logic signed [15:0] rv [NUM_AXES];
    logic signed [15:0] ofs;
    int                 sensor;
    int                 sum;
    bit                 done;
    done = 1'b0;
    s[0] = x;
    s[1] = y;
    s[2] = z;
    sensor = SENSOR_GYRO;
    if (m == MODE_ACCEL) begin
      sensor = SENSOR_ACCEL;
    end else if (m == MODE_MAG) begin
      sensor = SENSOR_MAG;
      s[0] = y;
      s[1] = x;
      s[2] = -z;
    end
    // first word of a calibration run drops the old bias
    if (m == MODE_GYRO_CAL && bias_count == 0) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        gyro_bias[a] = '0;
        bias_acc[a]  = 0;
      end
    end
    for (int a = 0; a < NUM_AXES; a++) hist[sensor][a][slot[sensor]] = s[a];
    slot[sensor] = (slot[sensor] + 1) % AVG_DEPTH;
    for (int a = 0; a < NUM_AXES; a++) begin
      sum = 0;
      for (int i = 0; i < AVG_DEPTH; i++) sum += hist[sensor][a][i];
      ofs = '0;
      if (sensor == SENSOR_GYRO) ofs = gyro_bias[a];
      else if (sensor == SENSOR_MAG) ofs = mag_trim[a];
      rv[a] = 16'((sum >>> AVG_SHIFT) - ofs);
    end
    if (m == MODE_GYRO_CAL) begin
      for (int a = 0; a < NUM_AXES; a++) bias_acc[a] += rv[a];
      bias_count++;
      if (bias_count >= CAL_RUN) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          gyro_bias[a] = 16'(bias_acc[a] >>> CAL_SHIFT);
          bias_acc[a]  = 0;
        end
        bias_count = 0;
        done = 1'b1;
      end
    end
    r.x    = rv[0];
    r.y    = rv[1];
    r.z    = rv[2];
    r.kind = m;
    r.done = done;
    return r;
  endfunction

  function automatic logic [15:0] axis_val();
    logic [15:0] v;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0: v = 16'h7fff;
          1: v = 16'h8000;
          2: v = 16'h0000;
          default: v = 16'hffff;
        endcase
      end
      1, 2, 3: v = 16'($urandom_range(0, 1023) - 512);
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endfunction

  // receiver side: random stall, decided at the edge
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // sample the output channel away from the edge, compare in order
  always @(negedge clk_i) begin
    avg_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (averages_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, got %h %h %h %h %b", $time,
                 out_x_o, out_y_o, out_z_o, sensor_kind_o, calibration_done_o);
      end else begin
        want = averages_due.pop_front();
        check_field("out_x", want.x, out_x_o);
        check_field("out_y", want.y, out_y_o);
        check_field("out_z", want.z, out_z_o);
        check_field("sensor_kind", {14'd0, want.kind}, {14'd0, sensor_kind_o});
        check_field("calibration_done", {15'd0, want.done}, {15'd0, calibration_done_o});
      end
    end
  end

  task automatic send_word(mode_e m, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                           bit use_fixed, avg_result_t fixed);
    bit          took;
    avg_result_t r;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= m;
    in_x_i     <= x;
    in_y_i     <= y;
    in_z_i     <= z;
    do begin
      @(negedge clk_i);
      took = !in_stall_o;
      @(posedge clk_i);
    end while (!took);
    r = average_word(m, x, y, z);
    averages_due.push_back(use_fixed ? fixed : r);
  endtask

  task automatic send_rand(mode_e m, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    send_word(m, x, y, z, 1'b0, '0);
  endtask

  // hold the input side until every word has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (averages_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] v);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(posedge clk_i);
    case (idx)
      REG_MAG_OFS_X: mag_trim[0] = v;
      REG_MAG_OFS_Y: mag_trim[1] = v;
      REG_MAG_OFS_Z: mag_trim[2] = v;
      default: ;
    endcase
  endtask

  task automatic set_offsets(logic [15:0] ox, logic [15:0] oy, logic [15:0] oz,
                             logic [15:0] junk);
    write_reg(REG_MAG_OFS_X, ox);
    write_reg(REG_MAG_OFS_Y, oy);
    write_reg(REG_MAG_OFS_Z, oz);
    write_reg(REG_UNUSED, junk);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_phase(int n_words);
    int          sent;
    int          len;
    logic [15:0] bx, by, bz;
    sent = 0;
    while (sent < n_words) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // calibration run around a fixed bias; some runs are cut short
          len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, CAL_RUN - 1) : CAL_RUN;
          if ($urandom_range(0, 4) == 0) begin
            bx = axis_val();
            by = axis_val();
            bz = axis_val();
          end else begin
            bx = 16'($urandom_range(0, 4000) - 2000);
            by = 16'($urandom_range(0, 4000) - 2000);
            bz = 16'($urandom_range(0, 4000) - 2000);
          end
          for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0) begin
              send_rand(MODE_GYRO, axis_val(), axis_val(), axis_val());
              sent++;
            end
            send_rand(MODE_GYRO_CAL, 16'(bx + $urandom_range(0, 63) - 32),
                      16'(by + $urandom_range(0, 63) - 32),
                      16'(bz + $urandom_range(0, 63) - 32));
            sent++;
          end
        end
        4, 5, 6, 7: begin
          len = $urandom_range(1, 16);
          for (int k = 0; k < len; k++) begin
            send_rand(mode_e'($urandom_range(0, 3)), axis_val(), axis_val(), axis_val());
            sent++;
          end
        end
        8: begin
          len = $urandom_range(1, 12);
          for (int k = 0; k < len; k++) begin
            send_rand(MODE_MAG, axis_val(), axis_val(), axis_val());
            sent++;
          end
        end
        default: begin
          wait_drained();
          send_rand(MODE_ACCEL, axis_val(), axis_val(), axis_val());
          sent++;
        end
      endcase
    end
  endtask

  initial begin
    for (int sn = 0; sn < NUM_SENSORS; sn++) begin
      slot[sn] = 0;
      for (int a = 0; a < NUM_AXES; a++)
        for (int i = 0; i < AVG_DEPTH; i++) hist[sn][a][i] = '0;
    end
    for (int a = 0; a < NUM_AXES; a++) begin
      gyro_bias[a] = '0;
      bias_acc[a]  = 0;
      mag_trim[a]  = '0;
    end
    bias_count = 0;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_offsets(16'h0000, 16'h0000, 16'h0000, 16'hffff);
    for (int i = 0; i < NUM_ROWS; i++)
      send_word(DIR_ROWS[i].mode, DIR_ROWS[i].x, DIR_ROWS[i].y, DIR_ROWS[i].z,
                DIR_ROWS[i].typed, DIR_ROWS[i].want);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_offsets(16'h0000, 16'h0000, 16'h0000, 16'h5a5a);
        1: set_offsets(16'h7fff, 16'h8000, 16'h0001, 16'hffff);
        2: set_offsets(16'h8000, 16'h7fff, 16'hffff, 16'h0000);
        default: set_offsets(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      run_phase(PHASE_WORDS);
      wait_drained();
    end

    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
